// File: rtl/http_request_byte_parser_defines.svh
// Assertion macros shared by the HTTP request byte parser RTL.
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define HRBP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HRBP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HRBP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define HRBP_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/hrbp_pkg.sv
// Package with types, constants and character helpers of the HTTP request byte parser.
`timescale 1ns / 1ps
`default_nettype none

package hrbp_pkg;

    // Width of the content length accumulator and of the reported body length.
    localparam int LEN_W  = 32;
    localparam int BLEN_W = 32;
    localparam int NAME_CHARS = 14;

    // Character codes.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_MAXCTL = 8'h1F;

    typedef enum logic [4:0] {
        PH_METHOD_START = 5'd0,
        PH_METHOD       = 5'd1,
        PH_URI          = 5'd2,
        PH_V_H          = 5'd3,
        PH_V_T1         = 5'd4,
        PH_V_T2         = 5'd5,
        PH_V_P          = 5'd6,
        PH_V_SLASH      = 5'd7,
        PH_MAJOR_START  = 5'd8,
        PH_MAJOR        = 5'd9,
        PH_MINOR_START  = 5'd10,
        PH_MINOR        = 5'd11,
        PH_NL_LINE      = 5'd12,
        PH_HDR_START    = 5'd13,
        PH_HDR_LWS      = 5'd14,
        PH_HDR_NAME     = 5'd15,
        PH_BEFORE_VALUE = 5'd16,
        PH_HDR_VALUE    = 5'd17,
        PH_NL_HDR       = 5'd18,
        PH_NL_END       = 5'd19,
        PH_BODY         = 5'd20
    } phase_t;

    typedef enum logic [1:0] {
        DIG_SKIP   = 2'd0,
        DIG_DIGITS = 2'd1,
        DIG_DONE   = 2'd2
    } dig_t;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_MALFORMED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CL_METHOD  = 3'd0,
        CL_URI     = 3'd1,
        CL_VERSION = 3'd2,
        CL_NAME    = 3'd3,
        CL_VALUE   = 3'd4,
        CL_BODY    = 3'd5,
        CL_DELIM   = 3'd6
    } class_t;

    // Parser state carried from one request byte to the next.
    typedef struct packed {
        phase_t             phase;
        logic               header_seen;
        logic [3:0]         name_pos;
        logic               name_match;
        logic               in_len;
        logic               len_found;
        dig_t               dig;
        logic               len_valid;
        logic [LEN_W-1:0]   len_value;
        logic [LEN_W-1:0]   body_rem;
    } state_t;

    // One result as it leaves the parser logic.
    typedef struct packed {
        logic [BLEN_W-1:0]  body_length;
        logic               header_begin;
        class_t             byte_class;
        status_t            status;
    } result_t;

    // Header name match progress.
    typedef struct packed {
        logic [3:0] pos;
        logic       match;
    } name_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_METHOD_START,
        header_seen: 1'b0,
        name_pos:    4'd0,
        name_match:  1'b1,
        in_len:      1'b0,
        len_found:   1'b0,
        dig:         DIG_SKIP,
        len_valid:   1'b0,
        len_value:   '0,
        body_rem:    '0
    };

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_MAXCTL) || (c == CH_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Characters of the header name "Content-Length".
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] r;
        case (pos)
            4'd0:    r = 8'h43;
            4'd1:    r = 8'h6F;
            4'd2:    r = 8'h6E;
            4'd3:    r = 8'h74;
            4'd4:    r = 8'h65;
            4'd5:    r = 8'h6E;
            4'd6:    r = 8'h74;
            4'd7:    r = 8'h2D;
            4'd8:    r = 8'h4C;
            4'd9:    r = 8'h65;
            4'd10:   r = 8'h6E;
            4'd11:   r = 8'h67;
            4'd12:   r = 8'h74;
            4'd13:   r = 8'h68;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Advance the name comparison by one byte.
    function automatic name_t name_step(input logic [3:0] pos, input logic match,
                                        input logic [7:0] c);
        name_t r;
        r.pos   = pos;
        r.match = 1'b0;
        if (match && (pos < 4'(NAME_CHARS)) && (c == name_char(pos))) begin
            r.pos   = pos + 4'd1;
            r.match = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hrbp_core.sv
// Per-byte parser logic: next parser state and the result for one request byte.
`timescale 1ns / 1ps
`default_nettype none

module hrbp_core import hrbp_pkg::*; (
    input  state_t      cur,
    input  logic [7:0]  data_byte,
    output state_t      nxt,
    output result_t     res
);

    logic              bad;
    logic              done;
    logic              ws;
    logic [LEN_W-1:0]  body_dec;
    logic [LEN_W+3:0]  acc;
    logic              acc_ovf;
    dig_t              vb_dig;
    logic              vb_valid;
    logic [LEN_W-1:0]  vb_value;
    name_t             nm_first;
    name_t             nm_cont;

    assign ws       = (data_byte == CH_SP) || (data_byte == CH_HT);
    assign body_dec = cur.body_rem - LEN_W'(1);
    assign nm_first = name_step(4'd0, 1'b1, data_byte);
    assign nm_cont  = name_step(cur.name_pos, cur.name_match, data_byte);

    // Decimal accumulate: value * 10 + digit, with the carry bits kept to spot overflow.
    assign acc     = ({4'b0, cur.len_value} << 3) + ({4'b0, cur.len_value} << 1)
                   + (LEN_W+4)'(data_byte[3:0]);
    assign acc_ovf = |acc[LEN_W+3:LEN_W];

    // Content length scan for one value byte.
    always_comb begin
        vb_dig   = cur.dig;
        vb_valid = cur.len_valid;
        vb_value = cur.len_value;
        if (cur.in_len) begin
            case (cur.dig)
                DIG_SKIP: begin
                    if (data_byte != CH_SP) begin
                        if (is_dig(data_byte)) begin
                            vb_dig   = DIG_DIGITS;
                            vb_valid = 1'b1;
                            vb_value = LEN_W'(data_byte[3:0]);
                        end else begin
                            vb_dig   = DIG_DONE;
                            vb_valid = 1'b0;
                        end
                    end
                end
                DIG_DIGITS: begin
                    if (!is_dig(data_byte)) begin
                        vb_dig = DIG_DONE;
                    end else if (acc_ovf) begin
                        vb_dig   = DIG_DONE;
                        vb_valid = 1'b0;
                    end else begin
                        vb_value = acc[LEN_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Decide whether this byte breaks the request or completes it.
    always_comb begin
        bad  = 1'b0;
        done = 1'b0;
        unique case (cur.phase)
            PH_METHOD_START: bad = !is_token(data_byte);
            PH_METHOD:       bad = (data_byte != CH_SP) && !is_token(data_byte);
            PH_URI:          bad = (data_byte != CH_SP) && is_ctl(data_byte);
            PH_V_H:          bad = (data_byte != CH_H);
            PH_V_T1,
            PH_V_T2:         bad = (data_byte != CH_T);
            PH_V_P:          bad = (data_byte != CH_P);
            PH_V_SLASH:      bad = (data_byte != CH_SLASH);
            PH_MAJOR_START,
            PH_MINOR_START:  bad = !is_dig(data_byte);
            PH_MAJOR:        bad = (data_byte != CH_DOT) && !is_dig(data_byte);
            PH_MINOR:        bad = (data_byte != CH_CR) && !is_dig(data_byte);
            PH_NL_LINE,
            PH_NL_HDR:       bad = (data_byte != CH_LF);
            PH_HDR_START:    bad = !((data_byte == CH_CR) || (cur.header_seen && ws)
                                     || is_token(data_byte));
            PH_HDR_LWS:      bad = (data_byte != CH_CR) && !ws && is_ctl(data_byte);
            PH_HDR_NAME:     bad = (data_byte != CH_COLON) && !is_token(data_byte);
            PH_BEFORE_VALUE: bad = (data_byte != CH_SP);
            PH_HDR_VALUE:    bad = (data_byte != CH_CR) && is_ctl(data_byte);
            PH_NL_END: begin
                bad  = (data_byte != CH_LF);
                done = (data_byte == CH_LF)
                     && !(cur.len_valid && (cur.len_value != '0));
            end
            PH_BODY:         done = (body_dec == '0);
            default:         bad = 1'b1;
        endcase
    end

    // Next parser state.
    always_comb begin
        nxt = cur;
        unique case (cur.phase)
            PH_METHOD_START: nxt.phase = PH_METHOD;
            PH_METHOD:       if (data_byte == CH_SP) nxt.phase = PH_URI;
            PH_URI:          if (data_byte == CH_SP) nxt.phase = PH_V_H;
            PH_V_H:          nxt.phase = PH_V_T1;
            PH_V_T1:         nxt.phase = PH_V_T2;
            PH_V_T2:         nxt.phase = PH_V_P;
            PH_V_P:          nxt.phase = PH_V_SLASH;
            PH_V_SLASH:      nxt.phase = PH_MAJOR_START;
            PH_MAJOR_START:  nxt.phase = PH_MAJOR;
            PH_MAJOR:        if (data_byte == CH_DOT) nxt.phase = PH_MINOR_START;
            PH_MINOR_START:  nxt.phase = PH_MINOR;
            PH_MINOR:        if (data_byte == CH_CR) nxt.phase = PH_NL_LINE;
            PH_NL_LINE,
            PH_NL_HDR:       nxt.phase = PH_HDR_START;
            PH_HDR_START: begin
                if (data_byte == CH_CR) begin
                    nxt.phase = PH_NL_END;
                end else if (cur.header_seen && ws) begin
                    nxt.phase = PH_HDR_LWS;
                end else begin
                    nxt.header_seen = 1'b1;
                    nxt.in_len      = 1'b0;
                    nxt.name_pos    = nm_first.pos;
                    nxt.name_match  = nm_first.match;
                    nxt.phase       = PH_HDR_NAME;
                end
            end
            PH_HDR_LWS: begin
                if (data_byte == CH_CR) begin
                    nxt.phase = PH_NL_HDR;
                end else if (!ws) begin
                    nxt.dig       = vb_dig;
                    nxt.len_valid = vb_valid;
                    nxt.len_value = vb_value;
                    nxt.phase     = PH_HDR_VALUE;
                end
            end
            PH_HDR_NAME: begin
                if (data_byte == CH_COLON) begin
                    if (cur.name_match && (cur.name_pos == 4'(NAME_CHARS))
                        && !cur.len_found) begin
                        nxt.len_found = 1'b1;
                        nxt.in_len    = 1'b1;
                    end
                    nxt.phase = PH_BEFORE_VALUE;
                end else begin
                    nxt.name_pos   = nm_cont.pos;
                    nxt.name_match = nm_cont.match;
                end
            end
            PH_BEFORE_VALUE: nxt.phase = PH_HDR_VALUE;
            PH_HDR_VALUE: begin
                if (data_byte == CH_CR) begin
                    nxt.phase = PH_NL_HDR;
                end else begin
                    nxt.dig       = vb_dig;
                    nxt.len_valid = vb_valid;
                    nxt.len_value = vb_value;
                end
            end
            PH_NL_END: begin
                nxt.body_rem = cur.len_value;
                nxt.phase    = PH_BODY;
            end
            PH_BODY:         nxt.body_rem = body_dec;
            default: begin
            end
        endcase
        // A finished or broken request starts the parser over.
        if (bad || done) begin
            nxt = STATE_RESET;
        end
    end

    // Result fields.
    always_comb begin
        res.header_begin = 1'b0;
        res.byte_class   = CL_DELIM;
        unique case (cur.phase)
            PH_METHOD_START: res.byte_class = CL_METHOD;
            PH_METHOD:       res.byte_class = (data_byte == CH_SP) ? CL_DELIM : CL_METHOD;
            PH_URI:          res.byte_class = (data_byte == CH_SP) ? CL_DELIM : CL_URI;
            PH_V_H, PH_V_T1, PH_V_T2, PH_V_P, PH_V_SLASH,
            PH_MAJOR_START, PH_MAJOR, PH_MINOR_START:
                             res.byte_class = CL_VERSION;
            PH_MINOR:        res.byte_class = (data_byte == CH_CR) ? CL_DELIM : CL_VERSION;
            PH_HDR_START: begin
                if ((data_byte == CH_CR) || (cur.header_seen && ws)) begin
                    res.byte_class = CL_DELIM;
                end else begin
                    res.byte_class   = CL_NAME;
                    res.header_begin = is_token(data_byte);
                end
            end
            PH_HDR_LWS:      res.byte_class = ((data_byte == CH_CR) || ws) ? CL_DELIM
                                                                          : CL_VALUE;
            PH_HDR_NAME:     res.byte_class = (data_byte == CH_COLON) ? CL_DELIM : CL_NAME;
            PH_HDR_VALUE:    res.byte_class = (data_byte == CH_CR) ? CL_DELIM : CL_VALUE;
            PH_BODY:         res.byte_class = CL_BODY;
            default:         res.byte_class = CL_DELIM;
        endcase
        if (bad) begin
            res.status = ST_MALFORMED;
        end else if (done) begin
            res.status = ST_COMPLETE;
        end else begin
            res.status = ST_INCOMPLETE;
        end
        res.body_length = (done && (cur.phase == PH_BODY)) ? BLEN_W'(cur.len_value) : '0;
    end

endmodule

`default_nettype wire

// File: rtl/http_request_byte_parser.sv
// Top level of the HTTP request byte parser: state register and output register.
//
// Usage:
// The block takes one byte of an HTTP request stream per request on the
// s_ channel (s_tdata[7:0]) and returns one result per byte on the m_ channel.
// Each result carries the parse status (incomplete, complete or malformed),
// the class of the byte, a flag on the first byte of each header name, and
// the body length once the request completes.
// The result of an accepted byte is registered onto m_tvalid in the next cycle.
// Throughput is one byte per cycle while m_tready is high; the only limit is the
// single output register, which is refilled in the same cycle that it drains.
// When the receiver stalls, the pending result holds and s_tready falls
// until m_tready returns; no byte is lost or repeated.
// After a complete or malformed result the parser starts over on the next
// byte with a fresh request.
// Reset (aresetn low at a rising edge) empties the output register and puts
// the parser back at the start of the method token.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_byte_parser_defines.svh"

module http_request_byte_parser import hrbp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [1:0] status, [4:2] byte_class,
                                        // [5] header_begin, [37:6] body_length, [39:38] 0
);

    state_t   state_reg;
    state_t   state_next;
    result_t  res_next;
    logic     m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic     s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Per-byte parse logic.
    hrbp_core u_core (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Parser state advances on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register: filled on accept, emptied when the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {2'b00, res_next.body_length, res_next.header_begin,
                            res_next.byte_class, res_next.status};
        end
    end

    // Checks.
    `HRBP_ASSERT_IMP(a_len_only_complete, aclk, aresetn,
        m_tvalid && (m_tdata[1:0] != ST_COMPLETE), m_tdata[37:6] == '0,
        "body length reported on a result that is not complete")
    `HRBP_ASSERT_NXT(a_restart_after_end, aclk, aresetn,
        s_accept && (res_next.status != ST_INCOMPLETE),
        state_reg.phase == PH_METHOD_START,
        "parser did not restart after a finished request")
    `HRBP_ASSERT_IMP(a_body_count_live, aclk, aresetn,
        state_reg.phase == PH_BODY, state_reg.len_valid && (state_reg.body_rem != '0),
        "body phase without a remaining byte count")

endmodule

`default_nettype wire

// File: sim/http_parse_checker.sv
// Checker for the HTTP request byte parser: predicts every result and compares it.
`timescale 1ns / 1ps

module http_parse_checker import hrbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [1:0] status, [4:2] byte_class,
                                    // [5] header_begin, [37:6] body_length, [39:38] 0
    output int          mismatch_count,
    output int          results_pending
);

    localparam logic [8*NAME_CHARS-1:0] LENGTH_NAME = "Content-Length";
    localparam logic [63:0]             LENGTH_MAX  = 64'hFFFF_FFFF;

    // What the parser should report for one request byte.
    typedef struct {
        status_t     status;
        class_t      byte_class;
        logic        header_begin;
        logic [31:0] body_length;
    } byte_verdict_t;

    byte_verdict_t expected_verdicts[$];

    // Parser state as the checker tracks it.
    phase_t      phase;
    logic        header_open;
    logic [3:0]  name_pos;
    logic        name_ok;
    logic        in_length;
    logic        length_claimed;
    dig_t        digit_phase;
    logic        length_ok;
    logic [31:0] length_acc;
    logic [31:0] body_left;

    function automatic logic is_control_byte(input logic [7:0] c);
        return c < 8'h20 || c == CH_DEL;
    endfunction

    function automatic logic is_digit_byte(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    // Token bytes are printable ASCII other than the separator set.
    function automatic logic is_token_byte(input logic [7:0] c);
        logic sep;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", " ", "\t": sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return c < 8'h80 && !is_control_byte(c) && !sep;
    endfunction

    task automatic clear_parser();
        phase          = PH_METHOD_START;
        header_open    = 1'b0;
        name_pos       = 4'd0;
        name_ok        = 1'b1;
        in_length      = 1'b0;
        length_claimed = 1'b0;
        digit_phase    = DIG_SKIP;
        length_ok      = 1'b0;
        length_acc     = '0;
        body_left      = '0;
    endtask

    // Follow the header name against "Content-Length", one byte at a time.
    task automatic match_length_name(input logic [7:0] c);
        int k;
        k = NAME_CHARS - 1 - int'(name_pos);
        if (name_ok && name_pos < 4'(NAME_CHARS) && c == LENGTH_NAME[8*k +: 8]) begin
            name_pos = name_pos + 4'd1;
        end else begin
            name_ok = 1'b0;
        end
    endtask

    // Scan the length value: skip spaces, then gather digits up to the first non-digit.
    task automatic scan_length_byte(input logic [7:0] c);
        logic [63:0] d;
        if (!in_length) return;
        if (digit_phase == DIG_SKIP) begin
            if (c == CH_SP) return;
            if (is_digit_byte(c)) begin
                digit_phase = DIG_DIGITS;
                length_ok   = 1'b1;
                length_acc  = '0;
            end else begin
                digit_phase = DIG_DONE;
                length_ok   = 1'b0;
                return;
            end
        end
        if (digit_phase == DIG_DIGITS) begin
            if (is_digit_byte(c)) begin
                d = 64'(c - 8'h30);
                // A value beyond the accumulator width gives no usable length.
                if (64'(length_acc) > (LENGTH_MAX - d) / 64'd10) begin
                    length_ok   = 1'b0;
                    digit_phase = DIG_DONE;
                end else begin
                    length_acc = 32'(64'(length_acc) * 64'd10 + d);
                end
            end else begin
                digit_phase = DIG_DONE;
            end
        end
    endtask

    // Advance the tracked parser by one byte and work out its result.
    task automatic parse_byte(input logic [7:0] c, output byte_verdict_t v);
        logic bad;
        bad            = 1'b0;
        v.status       = ST_INCOMPLETE;
        v.byte_class   = CL_DELIM;
        v.header_begin = 1'b0;
        v.body_length  = '0;
        case (phase)
            PH_METHOD_START: begin
                v.byte_class = CL_METHOD;
                if (is_token_byte(c)) phase = PH_METHOD;
                else bad = 1'b1;
            end
            PH_METHOD: begin
                if (c == CH_SP) begin
                    phase = PH_URI;
                end else begin
                    v.byte_class = CL_METHOD;
                    bad = !is_token_byte(c);
                end
            end
            PH_URI: begin
                if (c == CH_SP) begin
                    phase = PH_V_H;
                end else begin
                    v.byte_class = CL_URI;
                    bad = is_control_byte(c);
                end
            end
            // The literal "HTTP/" one letter at a time.
            PH_V_H: begin
                v.byte_class = CL_VERSION;
                if (c == CH_H) phase = PH_V_T1;
                else bad = 1'b1;
            end
            PH_V_T1: begin
                v.byte_class = CL_VERSION;
                if (c == CH_T) phase = PH_V_T2;
                else bad = 1'b1;
            end
            PH_V_T2: begin
                v.byte_class = CL_VERSION;
                if (c == CH_T) phase = PH_V_P;
                else bad = 1'b1;
            end
            PH_V_P: begin
                v.byte_class = CL_VERSION;
                if (c == CH_P) phase = PH_V_SLASH;
                else bad = 1'b1;
            end
            PH_V_SLASH: begin
                v.byte_class = CL_VERSION;
                if (c == CH_SLASH) phase = PH_MAJOR_START;
                else bad = 1'b1;
            end
            PH_MAJOR_START: begin
                v.byte_class = CL_VERSION;
                if (is_digit_byte(c)) phase = PH_MAJOR;
                else bad = 1'b1;
            end
            PH_MINOR_START: begin
                v.byte_class = CL_VERSION;
                if (is_digit_byte(c)) phase = PH_MINOR;
                else bad = 1'b1;
            end
            PH_MAJOR: begin
                v.byte_class = CL_VERSION;
                if (c == CH_DOT) phase = PH_MINOR_START;
                else bad = !is_digit_byte(c);
            end
            PH_MINOR: begin
                if (c == CH_CR) begin
                    phase = PH_NL_LINE;
                end else begin
                    v.byte_class = CL_VERSION;
                    bad = !is_digit_byte(c);
                end
            end
            PH_NL_LINE, PH_NL_HDR: begin
                if (c == CH_LF) phase = PH_HDR_START;
                else bad = 1'b1;
            end
            // Start of a line in the header section.
            PH_HDR_START: begin
                if (c == CH_CR) begin
                    phase = PH_NL_END;
                end else if (header_open && (c == CH_SP || c == CH_HT)) begin
                    phase = PH_HDR_LWS;
                end else if (is_token_byte(c)) begin
                    v.byte_class   = CL_NAME;
                    v.header_begin = 1'b1;
                    header_open    = 1'b1;
                    in_length      = 1'b0;
                    name_pos       = 4'd0;
                    name_ok        = 1'b1;
                    match_length_name(c);
                    phase = PH_HDR_NAME;
                end else begin
                    v.byte_class = CL_NAME;
                    bad = 1'b1;
                end
            end
            // Leading whitespace of a continuation line.
            PH_HDR_LWS: begin
                if (c == CH_CR) begin
                    phase = PH_NL_HDR;
                end else if (c == CH_SP || c == CH_HT) begin
                    v.byte_class = CL_DELIM;
                end else if (is_control_byte(c)) begin
                    v.byte_class = CL_VALUE;
                    bad = 1'b1;
                end else begin
                    v.byte_class = CL_VALUE;
                    scan_length_byte(c);
                    phase = PH_HDR_VALUE;
                end
            end
            PH_HDR_NAME: begin
                if (c == CH_COLON) begin
                    // Only the first exact match opens the length scan.
                    if (name_ok && name_pos == 4'(NAME_CHARS) && !length_claimed) begin
                        length_claimed = 1'b1;
                        in_length      = 1'b1;
                    end
                    phase = PH_BEFORE_VALUE;
                end else begin
                    v.byte_class = CL_NAME;
                    if (is_token_byte(c)) match_length_name(c);
                    else bad = 1'b1;
                end
            end
            PH_BEFORE_VALUE: begin
                if (c == CH_SP) phase = PH_HDR_VALUE;
                else bad = 1'b1;
            end
            PH_HDR_VALUE: begin
                if (c == CH_CR) begin
                    phase = PH_NL_HDR;
                end else begin
                    v.byte_class = CL_VALUE;
                    if (is_control_byte(c)) bad = 1'b1;
                    else scan_length_byte(c);
                end
            end
            // Blank line: either a body follows or the request is done.
            PH_NL_END: begin
                if (c != CH_LF) begin
                    bad = 1'b1;
                end else if (length_ok && length_acc != '0) begin
                    body_left = length_acc;
                    phase     = PH_BODY;
                end else begin
                    v.status = ST_COMPLETE;
                end
            end
            PH_BODY: begin
                v.byte_class = CL_BODY;
                body_left = body_left - 32'd1;
                if (body_left == '0) begin
                    v.status      = ST_COMPLETE;
                    v.body_length = length_acc;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) v.status = ST_MALFORMED;
        if (v.status != ST_INCOMPLETE) clear_parser();
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Results are matched first, so a byte accepted at the same edge queues behind them.
    always @(posedge aclk) begin
        byte_verdict_t want;
        if (!aresetn) begin
            clear_parser();
            expected_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t ns: result with no request byte waiting, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                    compare_field("byte_class", 32'(want.byte_class), 32'(m_tdata[4:2]));
                    compare_field("header_begin", 32'(want.header_begin), 32'(m_tdata[5]));
                    compare_field("body_length", want.body_length, m_tdata[37:6]);
                    compare_field("tdata padding", 32'd0, 32'(m_tdata[39:38]));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, want);
                expected_verdicts.insert(expected_verdicts.size(), want);
            end
        end
        results_pending = expected_verdicts.size();
    end

endmodule

// File: sim/tb_http_request_byte_parser.sv
// Testbench top for the HTTP request byte parser: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module tb_http_request_byte_parser import hrbp_pkg::*;;

    localparam int RANDOM_BYTES    = 950;
    localparam int DRAIN_INTERVAL  = 300;
    localparam int LONG_HOLD_AFTER = 400;
    localparam int LONG_HOLD_CYCLES = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        m_tready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;     // [1:0] status, [4:2] byte_class,
                              // [5] header_begin, [37:6] body_length, [39:38] 0
    int          mismatch_count;
    int          results_pending;

    int          bytes_sent;
    logic [7:0]  request_bytes[$];
    string       token_chars =
        "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    // Receiver state.
    int          ready_wait;
    int          ready_calm;
    bit          long_hold_done;

    http_request_byte_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    http_parse_checker parse_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 50 MHz clock.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Mostly no idling, some short gaps, a few long ones.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] token_byte();
        return token_chars[$urandom_range(0, token_chars.len() - 1)];
    endfunction

    // Any byte that is neither a control character nor a space.
    function automatic logic [7:0] uri_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // Header value byte: printable, space or high byte.
    function automatic logic [7:0] value_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // Append one byte to the request being built.
    task automatic add_byte(input logic [7:0] b);
        request_bytes.insert(request_bytes.size(), b);
    endtask

    task automatic push_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++) add_byte(t[i]);
    endtask

    task automatic push_digits(input int count);
        repeat (count) add_byte(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_line_end();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    // Build one request: request line, a few headers, blank line, body.
    task automatic build_request();
        int  n;
        int  pos;
        int  d1;
        int  d2;
        int  body_len;
        bit  length_used;
        request_bytes.delete();
        body_len    = 0;
        length_used = 1'b0;
        repeat ($urandom_range(1, 4)) add_byte(token_byte());
        add_byte(CH_SP);
        repeat ($urandom_range(1, 5)) add_byte(uri_byte());
        add_byte(CH_SP);
        push_text("HTTP/");
        push_digits($urandom_range(1, 2));
        add_byte(CH_DOT);
        push_digits($urandom_range(1, 2));
        push_line_end();
        n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 9) < 5) begin
                // Content-Length header with one of its value shapes.
                push_text("Content-Length: ");
                repeat ($urandom_range(0, 2)) add_byte(CH_SP);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        d1 = $urandom_range(0, 6);
                        push_text($sformatf("%0d", d1));
                        if (!length_used) body_len = d1;
                    end
                    4: begin
                        d1 = $urandom_range(7, 40);
                        push_text($sformatf("%0d;q", d1));
                        if (!length_used) body_len = d1;
                    end
                    5: ;
                    6: push_text($urandom_range(0, 1) ? "+3" : "-3");
                    7: push_text("abc");
                    8: push_text($urandom_range(0, 1) ? "4294967296" : "99999999999");
                    default: begin
                        // Digits carried on into a continuation line.
                        d1 = $urandom_range(1, 3);
                        d2 = $urandom_range(0, 9);
                        push_text($sformatf("%0d", d1));
                        push_line_end();
                        add_byte($urandom_range(0, 1) ? CH_SP : CH_HT);
                        push_text($sformatf("%0d", d2));
                        if (!length_used) body_len = d1 * 10 + d2;
                    end
                endcase
                length_used = 1'b1;
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 3))
                        0: push_text("Content-Lengt");
                        1: push_text("content-length");
                        2: push_text("Content-Lengthh");
                        default: push_text("Content-Type");
                    endcase
                end else begin
                    repeat ($urandom_range(1, 6)) add_byte(token_byte());
                end
                push_text(": ");
                repeat ($urandom_range(0, 6)) add_byte(value_byte());
                if ($urandom_range(0, 3) == 0) begin
                    push_line_end();
                    add_byte($urandom_range(0, 1) ? CH_SP : CH_HT);
                    repeat ($urandom_range(0, 4)) add_byte(value_byte());
                end
            end
            push_line_end();
        end
        push_line_end();
        repeat (body_len) add_byte(8'($urandom_range(0, 255)));
        // A few requests get a corrupted byte or are cut short.
        pos = $urandom_range(0, request_bytes.size() - 1);
        case ($urandom_range(0, 19))
            0, 1: request_bytes[pos] = 8'($urandom_range(0, 255));
            2: while (request_bytes.size() > pos + 1) void'(request_bytes.pop_back());
            default: ;
        endcase
    endtask

    // Offer one byte and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input bit calm);
        int gap;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_request();
        bit calm;
        calm = ($urandom_range(0, 4) == 0);
        foreach (request_bytes[i]) send_byte(request_bytes[i], calm);
    endtask

    // Stop offering until every result has come back.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
    endtask

    // Result side: random stalls, calm stretches, and one long hold.
    initial begin
        m_tready       = 1'b0;
        ready_wait     = 0;
        ready_calm     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && bytes_sent >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end else if (ready_wait > 0) begin
                m_tready <= 1'b0;
                ready_wait--;
            end else if (ready_calm > 0) begin
                m_tready <= 1'b1;
                ready_calm--;
            end else begin
                if ($urandom_range(0, 39) == 0) ready_calm = $urandom_range(20, 60);
                ready_wait = idle_cycles();
                if (ready_wait == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    ready_wait--;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int next_drain;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        bytes_sent = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Byte extremes at the start of a method, each one rejected on its own.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_SP, 1'b0);
        // A continuation line before any header is malformed.
        request_bytes.delete();
        push_text("G / HTTP/1.1\r\n ");
        send_request();
        wait_all_results();

        // Random requests, with a full drain every few hundred bytes.
        next_drain = bytes_sent + DRAIN_INTERVAL;
        while (bytes_sent < RANDOM_BYTES + 20) begin
            build_request();
            send_request();
            if (bytes_sent >= next_drain) begin
                wait_all_results();
                next_drain = bytes_sent + DRAIN_INTERVAL;
            end
        end

        wait_all_results();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
